// ----- rtl/core/tisp_pkg.sv -----
// Package for the telnet IAC stream parser: byte codes, parse phases,
// result kinds and the input and result transaction structs.
// No dependencies.
package tisp_pkg;

  // Width of the saturating consumed-byte counter (8 to 32)
  localparam int unsigned COUNT_WIDTH = 16;

  // Telnet byte codes
  localparam logic [7:0] B_IAC  = 8'hFF;
  localparam logic [7:0] B_SB   = 8'hFA;
  localparam logic [7:0] B_SE   = 8'hF0;
  localparam logic [7:0] B_WILL = 8'hFB;
  localparam logic [7:0] B_WONT = 8'hFC;
  localparam logic [7:0] B_DO   = 8'hFD;
  localparam logic [7:0] B_DONT = 8'hFE;

  // Maximum number of results that one input byte causes
  localparam int unsigned MAX_RES = 3;

  typedef enum logic [2:0] {
    PH_DATA    = 3'd0,
    PH_IAC     = 3'd1,
    PH_OPT     = 3'd2,
    PH_SB_OPT  = 3'd3,
    PH_SB_BODY = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_SEG_END = 2'd1,
    KIND_CMD     = 2'd2,
    KIND_DONE    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  value;
    logic [7:0]  option_code;
    logic [15:0] consumed_count;
    logic        final_result;
  } out_item_t;

endpackage

// ----- rtl/core/telnet_iac_stream_parser.sv -----
// Telnet IAC stream parser: one buffer byte in, data/segment/command/done
// results out. Depends on tisp_pkg.
//
// The first result of a byte is offered in the cycle after it is accepted.
// Throughput: one byte per cycle while each byte causes at most one result and
// out_ready_i is high; a byte that causes two or three results holds off the next
// byte until the single-result output port has drained all but its last result.
// Reset: rst_ni clears the parse state, the counter and the slot count and head.
module telnet_iac_stream_parser
  import tisp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Parse state
  phase_e                 phase_q, phase_d;
  logic [7:0]             verb_q, verb_d;
  logic                   body_iac_q, body_iac_d;
  logic                   seg_q, seg_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [COUNT_WIDTH-1:0] count_sum;

  // Result slots
  out_item_t res_q [MAX_RES];
  out_item_t res_n [MAX_RES];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] head_q, head_d;
  logic [1:0] res_num;

  logic [7:0] b;
  logic       last;
  logic       in_fire, out_fire;
  logic [1:0] add_amt;
  logic [COUNT_WIDTH:0] add_full;
  logic       is_verb;

  assign b       = in_data_i.data_byte;
  assign last    = in_data_i.end_of_buffer;
  assign is_verb = (b inside {[B_WILL:B_DONT]});

  // Handshake: load a new result set once the slots are empty or about to be
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = res_q[head_q];
  assign in_ready_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  // Next parse state
  always_comb begin
    phase_d    = phase_q;
    verb_d     = verb_q;
    body_iac_d = body_iac_q;
    seg_d      = seg_q;
    add_amt    = 2'd0;
    case (phase_q)
      PH_IAC: begin
        if (b == B_IAC) begin
          seg_d   = 1'b1;
          add_amt = 2'd2;
          phase_d = PH_DATA;
        end else begin
          seg_d = 1'b0;
          if (b == B_SB) begin
            add_amt = 2'd2;
            phase_d = PH_SB_OPT;
          end else if (is_verb) begin
            verb_d  = b;
            phase_d = PH_OPT;
          end else begin
            add_amt = 2'd2;
            phase_d = PH_DATA;
          end
        end
      end
      PH_OPT: begin
        add_amt = 2'd3;
        verb_d  = 8'h00;
        phase_d = PH_DATA;
      end
      PH_SB_OPT: begin
        add_amt    = 2'd1;
        body_iac_d = (b == B_IAC);
        phase_d    = PH_SB_BODY;
      end
      PH_SB_BODY: begin
        add_amt = 2'd1;
        if (body_iac_q && (b == B_SE)) begin
          body_iac_d = 1'b0;
          phase_d    = PH_DATA;
        end else begin
          body_iac_d = (b == B_IAC);
        end
      end
      default: begin
        if (b == B_IAC) begin
          phase_d = PH_IAC;
        end else begin
          seg_d   = 1'b1;
          add_amt = 2'd1;
          phase_d = PH_DATA;
        end
      end
    endcase

    // Saturating counter update
    add_full  = {1'b0, count_q} + {{(COUNT_WIDTH-1){1'b0}}, add_amt};
    count_sum = add_full[COUNT_WIDTH] ? COUNT_MAX : add_full[COUNT_WIDTH-1:0];
    count_d   = count_sum;

    // Buffer end returns everything to reset
    if (last) begin
      phase_d    = PH_DATA;
      verb_d     = 8'h00;
      body_iac_d = 1'b0;
      seg_d      = 1'b0;
      count_d    = '0;
    end
  end

  // Result generation for the byte at the input
  always_comb begin
    logic        seg;
    logic [31:0] cnt_ext;
    seg     = seg_q;
    res_num = 2'd0;
    cnt_ext = 32'(count_sum);
    for (int i = 0; i < MAX_RES; i++) begin
      res_n[i] = '{kind: KIND_DATA, value: 8'h00, option_code: 8'h00,
                   consumed_count: 16'h0000, final_result: 1'b0};
    end
    case (phase_q)
      PH_IAC: begin
        if (b == B_IAC) begin
          res_n[res_num].kind  = KIND_DATA;
          res_n[res_num].value = B_IAC;
          res_num = res_num + 2'd1;
          seg     = 1'b1;
        end else begin
          if (seg) begin
            res_n[res_num].kind = KIND_SEG_END;
            res_num = res_num + 2'd1;
            seg     = 1'b0;
          end
          if ((b != B_SB) && !is_verb) begin
            res_n[res_num].kind  = KIND_CMD;
            res_n[res_num].value = b;
            res_num = res_num + 2'd1;
          end
        end
      end
      PH_OPT: begin
        res_n[res_num].kind        = KIND_CMD;
        res_n[res_num].value       = verb_q;
        res_n[res_num].option_code = b;
        res_num = res_num + 2'd1;
      end
      PH_SB_OPT: begin
        res_n[res_num].kind        = KIND_CMD;
        res_n[res_num].value       = B_SB;
        res_n[res_num].option_code = b;
        res_num = res_num + 2'd1;
      end
      PH_SB_BODY: begin
        if (body_iac_q && (b == B_SE)) begin
          res_n[res_num].kind  = KIND_CMD;
          res_n[res_num].value = B_SE;
          res_num = res_num + 2'd1;
        end
      end
      default: begin
        if (b != B_IAC) begin
          res_n[res_num].kind  = KIND_DATA;
          res_n[res_num].value = b;
          res_num = res_num + 2'd1;
          seg     = 1'b1;
        end
      end
    endcase

    // Buffer end: close the segment, then report the count
    if (last) begin
      if (seg) begin
        res_n[res_num].kind = KIND_SEG_END;
        res_num = res_num + 2'd1;
      end
      res_n[res_num].kind           = KIND_DONE;
      res_n[res_num].consumed_count = cnt_ext[15:0];
      res_n[res_num].final_result   = 1'b1;
      res_num = res_num + 2'd1;
    end
  end

  // Slot bookkeeping
  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    if (in_fire) begin
      cnt_d  = res_num;
      head_d = 2'd0;
    end else if (out_fire) begin
      cnt_d  = cnt_q - 2'd1;
      head_d = head_q + 2'd1;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_DATA;
      verb_q     <= 8'h00;
      body_iac_q <= 1'b0;
      seg_q      <= 1'b0;
      count_q    <= '0;
      cnt_q      <= 2'd0;
      head_q     <= 2'd0;
    end else begin
      cnt_q  <= cnt_d;
      head_q <= head_d;
      if (in_fire) begin
        phase_q    <= phase_d;
        verb_q     <= verb_d;
        body_iac_q <= body_iac_d;
        seg_q      <= seg_d;
        count_q    <= count_d;
      end
    end
  end

  // Result payload slots
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int i = 0; i < MAX_RES; i++) begin
        res_q[i] <= res_n[i];
      end
    end
  end

  // Assertions
  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (cnt_q <= 2'd1))
    else $error("input ready while more than one result pending");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd0) |-> ((head_q + cnt_q) <= 2'(MAX_RES)))
    else $error("result slot head past the loaded results");

  a_final_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.final_result == (out_data_o.kind == KIND_DONE)))
    else $error("final flag disagrees with result kind");

  a_buffer_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.end_of_buffer) |=>
      ((phase_q == PH_DATA) && (count_q == '0) && !seg_q))
    else $error("parse state not cleared after buffer end");

endmodule
